// File: rtl/rcc_pkg.sv
// shared constants, register codes and interface types of the rgb 3x3 convolution block
`default_nettype none

package rcc_pkg;

   // image geometry
   localparam int MAX_WIDTH = 2048;
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int DIM_BITS  = 12;
   localparam int ROW_BITS  = 12;
   localparam int POS_BITS  = 11;

   // pixel and kernel layout
   localparam int CHAN_BITS = 8;
   localparam int NUM_CHAN  = 3;
   localparam int PIX_BITS  = NUM_CHAN * CHAN_BITS;
   localparam int LINE_BITS = 2 * PIX_BITS;
   localparam int COEF_BITS = 8;
   localparam int KERN_TAPS = 3;
   localparam int WIN_TAPS  = KERN_TAPS * KERN_TAPS;
   localparam int KERN_BITS = KERN_TAPS * COEF_BITS;

   // arithmetic widths
   localparam int PROD_BITS   = CHAN_BITS + COEF_BITS + 1;
   localparam int ROWSUM_BITS = PROD_BITS + 2;
   localparam int TOTAL_BITS  = ROWSUM_BITS + 2;

   // register defaults and limits
   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);
   localparam logic [DIM_BITS-1:0] WIDTH_MIN    = DIM_BITS'(3);
   localparam logic [DIM_BITS-1:0] WIDTH_MAX    = DIM_BITS'(MAX_WIDTH);
   localparam logic [DIM_BITS-1:0] HEIGHT_MIN   = DIM_BITS'(1);
   localparam logic [DIM_BITS-1:0] HEIGHT_MAX   = DIM_BITS'(2048);

   // register port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = CSR_ADDR_BITS - 2;

   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_IMAGE_WIDTH   = 3'd0,
      REG_IMAGE_HEIGHT  = 3'd1,
      REG_KERNEL_TOP    = 3'd2,
      REG_KERNEL_MIDDLE = 3'd3,
      REG_KERNEL_BOTTOM = 3'd4
   } rcc_reg_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_PAD   = 1'b1
   } rcc_op_type;

   // effective configuration seen by the datapath
   typedef struct packed {
      logic [DIM_BITS-1:0]                 width_last;
      logic [DIM_BITS-1:0]                 height;
      logic [KERN_TAPS-1:0][KERN_BITS-1:0] kernel;
   } rcc_cfg_type;

   // one filter window with the position of its result
   typedef struct packed {
      logic [WIN_TAPS-1:0][PIX_BITS-1:0] taps;
      logic [POS_BITS-1:0]               row;
      logic [POS_BITS-1:0]               col;
      logic                              done;
   } rcc_tap_type;

endpackage

`default_nettype wire

// File: rtl/rcc_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module rcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/rcc_csr.sv
// configuration registers behind the apb-style port
`default_nettype none

module rcc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [rcc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [rcc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [rcc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                   csr_pready,
   output rcc_pkg::rcc_cfg_type                   cfg
);

   logic [rcc_pkg::DIM_BITS-1:0]     width_ff;
   logic [rcc_pkg::DIM_BITS-1:0]     height_ff;
   logic [rcc_pkg::KERN_BITS-1:0]    ktop_ff;
   logic [rcc_pkg::KERN_BITS-1:0]    kmid_ff;
   logic [rcc_pkg::KERN_BITS-1:0]    kbot_ff;
   logic [rcc_pkg::REG_IDX_BITS-1:0] reg_idx;
   logic                             wr_en;
   logic [rcc_pkg::DIM_BITS-1:0]     width_eff;
   logic [rcc_pkg::DIM_BITS-1:0]     height_eff;

   assign reg_idx    = csr_paddr[rcc_pkg::CSR_ADDR_BITS-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rcc_pkg::WIDTH_RESET;
         height_ff <= rcc_pkg::HEIGHT_RESET;
         ktop_ff   <= '0;
         kmid_ff   <= '0;
         kbot_ff   <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            rcc_pkg::REG_IMAGE_WIDTH: begin
               width_ff <= csr_pwdata[rcc_pkg::DIM_BITS-1:0];
            end
            rcc_pkg::REG_IMAGE_HEIGHT: begin
               height_ff <= csr_pwdata[rcc_pkg::DIM_BITS-1:0];
            end
            rcc_pkg::REG_KERNEL_TOP: begin
               ktop_ff <= csr_pwdata[rcc_pkg::KERN_BITS-1:0];
            end
            rcc_pkg::REG_KERNEL_MIDDLE: begin
               kmid_ff <= csr_pwdata[rcc_pkg::KERN_BITS-1:0];
            end
            rcc_pkg::REG_KERNEL_BOTTOM: begin
               kbot_ff <= csr_pwdata[rcc_pkg::KERN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rcc_pkg::REG_IMAGE_WIDTH:   csr_prdata = rcc_pkg::CSR_DATA_BITS'(width_ff);
         rcc_pkg::REG_IMAGE_HEIGHT:  csr_prdata = rcc_pkg::CSR_DATA_BITS'(height_ff);
         rcc_pkg::REG_KERNEL_TOP:    csr_prdata = rcc_pkg::CSR_DATA_BITS'(ktop_ff);
         rcc_pkg::REG_KERNEL_MIDDLE: csr_prdata = rcc_pkg::CSR_DATA_BITS'(kmid_ff);
         rcc_pkg::REG_KERNEL_BOTTOM: csr_prdata = rcc_pkg::CSR_DATA_BITS'(kbot_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // saturate geometry to the supported range
   always_comb begin
      if (width_ff < rcc_pkg::WIDTH_MIN) begin
         width_eff = rcc_pkg::WIDTH_MIN;
      end else if (width_ff > rcc_pkg::WIDTH_MAX) begin
         width_eff = rcc_pkg::WIDTH_MAX;
      end else begin
         width_eff = width_ff;
      end
      if (height_ff < rcc_pkg::HEIGHT_MIN) begin
         height_eff = rcc_pkg::HEIGHT_MIN;
      end else if (height_ff > rcc_pkg::HEIGHT_MAX) begin
         height_eff = rcc_pkg::HEIGHT_MAX;
      end else begin
         height_eff = height_ff;
      end
   end

   assign cfg.width_last = width_eff - rcc_pkg::DIM_BITS'(1);
   assign cfg.height     = height_eff;
   assign cfg.kernel[0]  = ktop_ff;
   assign cfg.kernel[1]  = kmid_ff;
   assign cfg.kernel[2]  = kbot_ff;

endmodule

`default_nettype wire

// File: rtl/rcc_window.sv
// raster counters, line buffer read-modify-write and the 3x3 window
`default_nettype none

module rcc_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rcc_pkg::rcc_cfg_type          cfg,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic [rcc_pkg::CHAN_BITS-1:0] req_red_in,
   input  wire logic [rcc_pkg::CHAN_BITS-1:0] req_green_in,
   input  wire logic [rcc_pkg::CHAN_BITS-1:0] req_blue_in,
   output logic                               tap_valid,
   input  wire logic                          tap_ready,
   output rcc_pkg::rcc_tap_type               tap
);

   // raster position of the next request
   logic [rcc_pkg::COL_BITS-1:0] col_ff, col_in;
   logic [rcc_pkg::ROW_BITS-1:0] row_ff, row_in;

   // request waiting for its line buffer read
   logic                         s1_valid_ff, s1_valid_in;
   logic [rcc_pkg::PIX_BITS-1:0] s1_px_ff;
   logic [rcc_pkg::COL_BITS-1:0] s1_col_ff;
   logic                         s1_top_zero_ff;
   logic                         s1_emit_ff;
   logic [rcc_pkg::POS_BITS-1:0] s1_out_row_ff;
   logic [rcc_pkg::POS_BITS-1:0] s1_out_col_ff;
   logic                         s1_done_ff;

   // window and the result position that belongs to it
   logic                                             tap_valid_ff, tap_valid_in;
   logic [rcc_pkg::WIN_TAPS-1:0][rcc_pkg::PIX_BITS-1:0] window_ff, window_in;
   logic [rcc_pkg::POS_BITS-1:0]                     tap_row_ff;
   logic [rcc_pkg::POS_BITS-1:0]                     tap_col_ff;
   logic                                             tap_done_ff;

   logic                          accept;
   logic                          move1;
   logic                          s1_ready;
   logic                          col_last;
   logic [rcc_pkg::PIX_BITS-1:0]  px;
   logic                          emit;
   logic [rcc_pkg::LINE_BITS-1:0] line_rd;
   logic [rcc_pkg::PIX_BITS-1:0]  line_above;
   logic [rcc_pkg::PIX_BITS-1:0]  line_mid;
   logic [rcc_pkg::PIX_BITS-1:0]  top_px;

   assign move1     = s1_valid_ff && (!tap_valid_ff || tap_ready);
   assign s1_ready  = !s1_valid_ff || move1;
   assign req_stall = reset || !s1_ready;
   assign accept    = req_valid && !req_stall;

   assign col_last = {1'b0, col_ff} >= cfg.width_last;

   // pad items and the pad row enter as black pixels
   always_comb begin
      if ((req_op == rcc_pkg::OP_PAD) || (row_ff >= cfg.height)) begin
         px = '0;
      end else begin
         px = {req_red_in, req_green_in, req_blue_in};
      end
   end

   assign emit = (row_ff != '0) && (row_ff <= cfg.height)
              && (col_ff >= rcc_pkg::COL_BITS'(2)) && ({1'b0, col_ff} <= cfg.width_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            if (row_ff >= cfg.height) begin
               row_in = '0;
            end else begin
               row_in = row_ff + rcc_pkg::ROW_BITS'(1);
            end
         end else begin
            col_in = col_ff + rcc_pkg::COL_BITS'(1);
         end
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (move1) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff       <= px;
         s1_col_ff      <= col_ff;
         s1_top_zero_ff <= row_ff <= rcc_pkg::ROW_BITS'(1);
         s1_emit_ff     <= emit;
         s1_out_row_ff  <= rcc_pkg::POS_BITS'(row_ff - rcc_pkg::ROW_BITS'(1));
         s1_out_col_ff  <= col_ff - rcc_pkg::COL_BITS'(1);
         s1_done_ff     <= (row_ff == cfg.height) && ({1'b0, col_ff} == cfg.width_last);
      end
   end

   // each entry holds the column of the two previous rows: {above, middle}
   rcc_ram #(
      .WIDTH(rcc_pkg::LINE_BITS),
      .DEPTH(rcc_pkg::MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (move1),
      .wr_addr (s1_col_ff),
      .wr_data ({line_mid, s1_px_ff}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   assign line_above = line_rd[rcc_pkg::LINE_BITS-1:rcc_pkg::PIX_BITS];
   assign line_mid   = line_rd[rcc_pkg::PIX_BITS-1:0];
   assign top_px     = s1_top_zero_ff ? '0 : line_above;

   always_comb begin
      for (int i = 0; i < rcc_pkg::KERN_TAPS; i++) begin
         window_in[i*3]   = window_ff[i*3+1];
         window_in[i*3+1] = window_ff[i*3+2];
      end
      window_in[2] = top_px;
      window_in[5] = line_mid;
      window_in[8] = s1_px_ff;
   end

   always_comb begin
      if (move1) begin
         tap_valid_in = s1_emit_ff;
      end else if (tap_ready) begin
         tap_valid_in = 1'b0;
      end else begin
         tap_valid_in = tap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_valid_ff <= 1'b0;
         window_ff    <= '0;
      end else begin
         tap_valid_ff <= tap_valid_in;
         if (move1) begin
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move1) begin
         tap_row_ff  <= s1_out_row_ff;
         tap_col_ff  <= s1_out_col_ff;
         tap_done_ff <= s1_done_ff;
      end
   end

   assign tap_valid = tap_valid_ff;
   assign tap.taps  = window_ff;
   assign tap.row   = tap_row_ff;
   assign tap.col   = tap_col_ff;
   assign tap.done  = tap_done_ff;

   a_line_no_collide: assert property (@(posedge clock) disable iff (reset)
      (move1 && accept) |-> (s1_col_ff != col_ff))
      else $error("line buffer write and read hit the same column");

   a_line_data_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !move1) |=> $stable(line_rd))
      else $error("line buffer read data lost while waiting");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request did not reach the read stage");

   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      (tap_valid_ff && !tap_ready) |=> $stable(window_ff))
      else $error("window changed under a waiting result");

endmodule

`default_nettype wire

// File: rtl/rcc_filter.sv
// per-channel 3x3 multiply-accumulate, saturation and result register
`default_nettype none

module rcc_filter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rcc_pkg::rcc_cfg_type          cfg,
   input  wire logic                          tap_valid,
   output logic                               tap_ready,
   input  wire rcc_pkg::rcc_tap_type          tap,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [rcc_pkg::CHAN_BITS-1:0]      rsp_red_out,
   output logic [rcc_pkg::CHAN_BITS-1:0]      rsp_green_out,
   output logic [rcc_pkg::CHAN_BITS-1:0]      rsp_blue_out,
   output logic [rcc_pkg::POS_BITS-1:0]       rsp_out_row,
   output logic [rcc_pkg::POS_BITS-1:0]       rsp_out_col,
   output logic                               rsp_frame_done
);

   function automatic logic signed [rcc_pkg::PROD_BITS-1:0] tap_product(
      input logic [rcc_pkg::CHAN_BITS-1:0] pix,
      input logic [rcc_pkg::COEF_BITS-1:0] coef
   );
      logic signed [rcc_pkg::PROD_BITS-1:0] pix_s;
      logic signed [rcc_pkg::PROD_BITS-1:0] coef_s;
      pix_s  = $signed({{(rcc_pkg::PROD_BITS-rcc_pkg::CHAN_BITS){1'b0}}, pix});
      coef_s = rcc_pkg::PROD_BITS'($signed(coef));
      return pix_s * coef_s;
   endfunction

   function automatic logic [rcc_pkg::CHAN_BITS-1:0] saturate(
      input logic signed [rcc_pkg::TOTAL_BITS-1:0] total
   );
      logic signed [rcc_pkg::TOTAL_BITS-1:0] top;
      top = rcc_pkg::TOTAL_BITS'((1 << rcc_pkg::CHAN_BITS) - 1);
      if (total < 0) begin
         return '0;
      end else if (total > top) begin
         return '1;
      end else begin
         return total[rcc_pkg::CHAN_BITS-1:0];
      end
   endfunction

   logic signed [rcc_pkg::ROWSUM_BITS-1:0] row_sum_in [rcc_pkg::NUM_CHAN][rcc_pkg::KERN_TAPS];
   logic signed [rcc_pkg::ROWSUM_BITS-1:0] row_sum_ff [rcc_pkg::NUM_CHAN][rcc_pkg::KERN_TAPS];
   logic                                   s3_valid_ff, s3_valid_in;
   logic [rcc_pkg::POS_BITS-1:0]           s3_row_ff;
   logic [rcc_pkg::POS_BITS-1:0]           s3_col_ff;
   logic                                   s3_done_ff;

   logic signed [rcc_pkg::TOTAL_BITS-1:0]  total [rcc_pkg::NUM_CHAN];
   logic [rcc_pkg::CHAN_BITS-1:0]          chan_in [rcc_pkg::NUM_CHAN];
   logic [rcc_pkg::CHAN_BITS-1:0]          chan_ff [rcc_pkg::NUM_CHAN];
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [rcc_pkg::POS_BITS-1:0]           rsp_row_ff;
   logic [rcc_pkg::POS_BITS-1:0]           rsp_col_ff;
   logic                                   rsp_done_ff;

   logic out_ready;
   logic s3_ready;
   logic move2;
   logic move3;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign tap_ready = s3_ready;
   assign move2     = tap_valid && s3_ready;
   assign move3     = s3_valid_ff && out_ready;

   // red sits in the top byte of a pixel
   always_comb begin
      for (int ch = 0; ch < rcc_pkg::NUM_CHAN; ch++) begin
         for (int i = 0; i < rcc_pkg::KERN_TAPS; i++) begin
            row_sum_in[ch][i] =
                 rcc_pkg::ROWSUM_BITS'(tap_product(
                    tap.taps[i*3][(rcc_pkg::NUM_CHAN-1-ch)*rcc_pkg::CHAN_BITS +: rcc_pkg::CHAN_BITS],
                    cfg.kernel[i][0 +: rcc_pkg::COEF_BITS]))
               + rcc_pkg::ROWSUM_BITS'(tap_product(
                    tap.taps[i*3+1][(rcc_pkg::NUM_CHAN-1-ch)*rcc_pkg::CHAN_BITS +: rcc_pkg::CHAN_BITS],
                    cfg.kernel[i][rcc_pkg::COEF_BITS +: rcc_pkg::COEF_BITS]))
               + rcc_pkg::ROWSUM_BITS'(tap_product(
                    tap.taps[i*3+2][(rcc_pkg::NUM_CHAN-1-ch)*rcc_pkg::CHAN_BITS +: rcc_pkg::CHAN_BITS],
                    cfg.kernel[i][2*rcc_pkg::COEF_BITS +: rcc_pkg::COEF_BITS]));
         end
      end
   end

   always_comb begin
      if (move2) begin
         s3_valid_in = 1'b1;
      end else if (move3) begin
         s3_valid_in = 1'b0;
      end else begin
         s3_valid_in = s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move2) begin
         row_sum_ff <= row_sum_in;
         s3_row_ff  <= tap.row;
         s3_col_ff  <= tap.col;
         s3_done_ff <= tap.done;
      end
   end

   always_comb begin
      for (int ch = 0; ch < rcc_pkg::NUM_CHAN; ch++) begin
         total[ch] = rcc_pkg::TOTAL_BITS'(row_sum_ff[ch][0])
                   + rcc_pkg::TOTAL_BITS'(row_sum_ff[ch][1])
                   + rcc_pkg::TOTAL_BITS'(row_sum_ff[ch][2]);
         chan_in[ch] = saturate(total[ch]);
      end
   end

   always_comb begin
      if (move3) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move3) begin
         chan_ff     <= chan_in;
         rsp_row_ff  <= s3_row_ff;
         rsp_col_ff  <= s3_col_ff;
         rsp_done_ff <= s3_done_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = chan_ff[0];
   assign rsp_green_out  = chan_ff[1];
   assign rsp_blue_out   = chan_ff[2];
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_frame_done = rsp_done_ff;

endmodule

`default_nettype wire

// File: rtl/rgb_conv3x3_clamp_top.sv
// top level of the streaming rgb 3x3 convolution filter with saturation
`default_nettype none

// Streaming 3x3 convolution on RGB pixels in raster order. Each request is
// one pixel (op = 0) or a zero pad item (op = 1); after the last image row the
// source sends one full row of pad items so the bottom row can be filtered.
// Each color channel is filtered on its own with the signed 8-bit kernel held
// in kernel_top/middle/bottom (left coefficient in bits 7:0), neighbors
// outside the image read as zero, and the sum saturates to 0..255. A result
// comes out for columns 1 to width-2 of every row, one row and one column
// behind the input; frame_done marks the last result of the image. Width is
// used saturated to 3..2048 and height to 1..2048. The block takes one request
// per clock while the result side does not stall: the two previous rows live
// in a single 2048 x 48 line buffer ram that is read once when a request is
// taken and written back once as it moves on to the window, and that one read
// plus one write per clock sets the rate. Four stages (line buffer read,
// window, row sums, result register) lie between a request and its result
// and decouple the two sides, so requests keep flowing while a result waits,
// until the stages fill. The line buffer needs no clearing after reset: the
// top row of the first output row is forced to zero. Registers sit at byte
// address 4*i and should only be written while no request is in flight.
module rgb_conv3x3_clamp_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_op,
   input  wire logic [rcc_pkg::CHAN_BITS-1:0]     req_red_in,
   input  wire logic [rcc_pkg::CHAN_BITS-1:0]     req_green_in,
   input  wire logic [rcc_pkg::CHAN_BITS-1:0]     req_blue_in,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [rcc_pkg::CHAN_BITS-1:0]     rsp_red_out,
   output logic      [rcc_pkg::CHAN_BITS-1:0]     rsp_green_out,
   output logic      [rcc_pkg::CHAN_BITS-1:0]     rsp_blue_out,
   output logic      [rcc_pkg::POS_BITS-1:0]      rsp_out_row,
   output logic      [rcc_pkg::POS_BITS-1:0]      rsp_out_col,
   output logic                                   rsp_frame_done,
   // register port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [rcc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [rcc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [rcc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                   csr_pready
);

   // saturated geometry and kernel rows
   rcc_pkg::rcc_cfg_type cfg;

   // window handed from the line buffer side to the arithmetic
   logic                 tap_valid;
   logic                 tap_ready;
   rcc_pkg::rcc_tap_type tap;

   rcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // raster counters, line buffer and 3x3 window
   rcc_window u_window (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .tap_valid    (tap_valid),
      .tap_ready    (tap_ready),
      .tap          (tap)
   );

   // products, row sums, saturation and the result register
   rcc_filter u_filter (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .tap_valid      (tap_valid),
      .tap_ready      (tap_ready),
      .tap            (tap),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

`default_nettype wire
